### design/bpa_pkg.sv
// Shared types, constants and the table slot function of the buddy page allocator.
// Used by the RAM-backed datapath, the controller and the top level.
`timescale 1ns / 1ps

package bpa_pkg;

	localparam int NUM_ORDERS = 10;
	localparam int TOP_ORDER  = NUM_ORDERS - 1;
	localparam int PAGE_LOG   = 12;
	localparam int PAGE_BYTES = 1 << PAGE_LOG;
	localparam int PAGE_W     = TOP_ORDER;
	localparam int SLOT_W     = NUM_ORDERS;
	localparam int TABLE_SIZE = (1 << NUM_ORDERS) - 1;
	localparam int ORD_W      = 4;
	localparam int ADDR_W     = 48;
	localparam int REQ_W      = 24;

	// per-block status codes held in the table
	typedef enum logic [1:0] {
		BS_FREE     = 2'd0,
		BS_ALLOC    = 2'd1,
		BS_ABSORBED = 2'd2,
		BS_SPLIT    = 2'd3
	} bstat_t;

	// result status codes
	typedef enum logic [1:0] {
		RS_OK        = 2'd0,
		RS_TOO_LARGE = 2'd1,
		RS_NO_FREE   = 2'd2,
		RS_BAD_FREE  = 2'd3
	} rstat_t;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_SCAN_START,
		OP_SCAN,
		OP_SPLIT_A,
		OP_SPLIT_B,
		OP_MARK,
		OP_CHILD,
		OP_RD_P0,
		OP_RD_O1,
		OP_O_INC,
		OP_MERGE_INIT,
		OP_RD_BUD,
		OP_MERGE_A,
		OP_MERGE_B,
		OP_SET_FREE,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t    op;
		rstat_t rstat;
		logic   load;
	} cmd_t;

	typedef struct packed {
		logic   is_free_req;
		logic   too_large;
		logic   no_free;
		logic   bad_addr;
		bstat_t rd;
		logic   aligned;
		logic   ord_top;
		logic   lvl_top;
		logic   lvl_ne_ord;
		logic   ord_zero;
		logic   child_last;
		logic   scan_last;
		logic   clear_last;
	} sts_t;

	// table slot of the block of order k that holds page pg
	function automatic logic [SLOT_W-1:0] slot_f(input logic [ORD_W-1:0] k,
		input logic [PAGE_W-1:0] pg);
		logic [SLOT_W:0] one_v;
		logic [SLOT_W:0] base_v;
		logic [4:0]      sh;
		one_v  = (SLOT_W+1)'(1);
		sh     = 5'(NUM_ORDERS) - {1'b0, k};
		base_v = (one_v << NUM_ORDERS) - (one_v << sh);
		slot_f = base_v[SLOT_W-1:0] + SLOT_W'(pg >> k);
	endfunction

endpackage

### design/bpa_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bpa_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1023
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/bpa_datapath.sv
// Datapath: status table RAM, free-list heads, request registers and result word.
// Depends on bpa_pkg and bpa_ram; driven by bpa_ctrl through cmd_t.
`timescale 1ns / 1ps

module bpa_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bpa_pkg::cmd_t                cmd,
	output bpa_pkg::sts_t                sts,
	input  logic                         cfg_we,
	input  logic [bpa_pkg::ADDR_W-1:0]   cfg_base,
	input  logic                         req_kind,
	input  logic [bpa_pkg::REQ_W-1:0]    req_bytes,
	input  logic [bpa_pkg::ADDR_W-1:0]   req_addr,
	output logic [1:0]                   res_status,
	output logic [bpa_pkg::ADDR_W-1:0]   res_address,
	output logic [bpa_pkg::ORD_W-1:0]    res_order
);

	localparam int PW = bpa_pkg::PAGE_W;
	localparam int OW = bpa_pkg::ORD_W;
	localparam int SW = bpa_pkg::SLOT_W;
	localparam int AW = bpa_pkg::ADDR_W;
	localparam int NO = bpa_pkg::NUM_ORDERS;

	logic [AW-1:0] base_q;
	logic          kind_q, tl_q, nf_q, bad_q;
	logic [OW-1:0] ord_q, lvl_q, kk_q, sk_q, sk_s1;
	logic [PW-1:0] pg_q, blk_q, jj_q, sj_q, sj_s1;
	logic [SW-1:0] n_q;
	logic          scan_vld_s1;
	logic [NO-1:0] ffv_q;
	logic [PW-1:0] ffi_q [NO];

	logic          we;
	logic [SW-1:0] waddr, raddr;
	bpa_pkg::bstat_t wdata;
	logic [1:0]    rdata;

	logic [OW-1:0] t_c;
	logic          tl_c, found_c;
	logic [OW-1:0] i_c;
	logic [PW-1:0] s_c;
	logic [AW:0]   diff_c;
	logic          bad_c;
	logic [PW-1:0] bud, jj_end, sj_end, amask;

	bpa_ram #(.WIDTH(2), .DEPTH(bpa_pkg::TABLE_SIZE)) u_tbl (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// allocate request decode: fitting order and lowest free block at or above it
	always_comb begin
		t_c = OW'(bpa_pkg::TOP_ORDER);
		for (int tt = bpa_pkg::TOP_ORDER - 1; tt >= 0; tt--) begin
			if (64'(req_bytes) <= (64'(bpa_pkg::PAGE_BYTES) << tt)) begin
				t_c = OW'(tt);
			end
		end
		tl_c = 64'(req_bytes) > (64'(bpa_pkg::PAGE_BYTES) << bpa_pkg::TOP_ORDER);
		i_c = '0;
		s_c = '0;
		found_c = 1'b0;
		for (int ii = NO - 1; ii >= 0; ii--) begin
			if (OW'(ii) >= t_c && ffv_q[ii]) begin
				i_c = OW'(ii);
				s_c = ffi_q[ii];
				found_c = 1'b1;
			end
		end
	end

	// free request decode: offset, page alignment and range
	assign diff_c = {1'b0, req_addr} - {1'b0, base_q};
	assign bad_c = diff_c[AW] | (|diff_c[bpa_pkg::PAGE_LOG-1:0])
		| (|diff_c[AW-1:bpa_pkg::PAGE_LOG+PW]);

	// loop bounds, buddy block and alignment mask
	assign bud    = blk_q ^ (PW'(1) << lvl_q);
	assign jj_end = PW'(((PW+1)'(1) << (ord_q - kk_q)) - (PW+1)'(1));
	assign sj_end = PW'(((PW+1)'(1) << (OW'(bpa_pkg::TOP_ORDER) - sk_q)) - (PW+1)'(1));
	assign amask  = ~({PW{1'b1}} << ({1'b0, ord_q} + 5'd1));

	// table port selection
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = bpa_pkg::BS_FREE;
		raddr = '0;
		case (cmd.op)
			bpa_pkg::OP_CLEAR: begin
				we = 1'b1;
				waddr = n_q;
				wdata = (n_q == SW'(bpa_pkg::TABLE_SIZE - 1)) ? bpa_pkg::BS_FREE
					: bpa_pkg::BS_ABSORBED;
			end
			bpa_pkg::OP_SCAN:   raddr = n_q;
			bpa_pkg::OP_SPLIT_A: begin
				we = 1'b1;
				waddr = bpa_pkg::slot_f(lvl_q, pg_q);
				wdata = bpa_pkg::BS_SPLIT;
			end
			bpa_pkg::OP_SPLIT_B: begin
				we = 1'b1;
				waddr = bpa_pkg::slot_f(lvl_q - OW'(1), pg_q | (PW'(1) << (lvl_q - OW'(1))));
				wdata = bpa_pkg::BS_FREE;
			end
			bpa_pkg::OP_MARK: begin
				we = 1'b1;
				waddr = bpa_pkg::slot_f(ord_q, pg_q);
				wdata = bpa_pkg::BS_ALLOC;
			end
			bpa_pkg::OP_CHILD: begin
				we = 1'b1;
				waddr = bpa_pkg::slot_f(kk_q, pg_q) + SW'(jj_q);
				wdata = kind_q ? bpa_pkg::BS_ABSORBED : bpa_pkg::BS_ALLOC;
			end
			bpa_pkg::OP_RD_P0:  raddr = bpa_pkg::slot_f('0, pg_q);
			bpa_pkg::OP_RD_O1:  raddr = bpa_pkg::slot_f(ord_q + OW'(1), pg_q);
			bpa_pkg::OP_RD_BUD: raddr = bpa_pkg::slot_f(lvl_q, bud);
			bpa_pkg::OP_MERGE_A: begin
				we = 1'b1;
				waddr = bpa_pkg::slot_f(lvl_q, blk_q);
				wdata = bpa_pkg::BS_ABSORBED;
			end
			bpa_pkg::OP_MERGE_B: begin
				we = 1'b1;
				waddr = bpa_pkg::slot_f(lvl_q, bud);
				wdata = bpa_pkg::BS_ABSORBED;
			end
			bpa_pkg::OP_SET_FREE: begin
				we = 1'b1;
				waddr = bpa_pkg::slot_f(lvl_q, blk_q);
				wdata = bpa_pkg::BS_FREE;
			end
			default: ;
		endcase
	end

	// control registers: base, sweep counter, free-list heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			n_q <= '0;
			scan_vld_s1 <= 1'b0;
			ffv_q <= NO'(1) << bpa_pkg::TOP_ORDER;
			for (int k = 0; k < NO; k++) begin
				ffi_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				base_q <= cfg_base;
			end
			scan_vld_s1 <= (cmd.op == bpa_pkg::OP_SCAN);
			if (cmd.op == bpa_pkg::OP_CLEAR || cmd.op == bpa_pkg::OP_SCAN) begin
				n_q <= n_q + SW'(1);
			end else if (cmd.op == bpa_pkg::OP_SCAN_START) begin
				n_q <= '0;
			end
			if (cmd.op == bpa_pkg::OP_SCAN_START) begin
				ffv_q <= '0;
			end else begin
				for (int k = 0; k < NO; k++) begin
					if (scan_vld_s1 && rdata == bpa_pkg::BS_FREE && !ffv_q[k]
						&& sk_s1 == OW'(k)) begin
						ffv_q[k] <= 1'b1;
						ffi_q[k] <= sj_s1 << sk_s1;
					end
				end
			end
		end
	end

	// request, loop and result registers
	always_ff @(posedge clk) begin
		sk_s1 <= sk_q;
		sj_s1 <= sj_q;
		if (cmd.load) begin
			kind_q <= req_kind;
			tl_q <= tl_c;
			nf_q <= !found_c;
			bad_q <= bad_c;
			kk_q <= '0;
			jj_q <= '0;
			if (req_kind) begin
				ord_q <= '0;
				pg_q <= diff_c[bpa_pkg::PAGE_LOG +: PW];
			end else begin
				ord_q <= t_c;
				lvl_q <= i_c;
				pg_q <= s_c;
			end
		end
		case (cmd.op)
			bpa_pkg::OP_SCAN_START: begin
				sk_q <= '0;
				sj_q <= '0;
			end
			bpa_pkg::OP_SCAN: begin
				if (sj_q == sj_end) begin
					sj_q <= '0;
					sk_q <= sk_q + OW'(1);
				end else begin
					sj_q <= sj_q + PW'(1);
				end
			end
			bpa_pkg::OP_SPLIT_B: lvl_q <= lvl_q - OW'(1);
			bpa_pkg::OP_CHILD: begin
				if (jj_q == jj_end) begin
					jj_q <= '0;
					kk_q <= kk_q + OW'(1);
				end else begin
					jj_q <= jj_q + PW'(1);
				end
			end
			bpa_pkg::OP_O_INC: ord_q <= ord_q + OW'(1);
			bpa_pkg::OP_MERGE_INIT: begin
				lvl_q <= ord_q;
				blk_q <= pg_q;
			end
			bpa_pkg::OP_MERGE_B: begin
				blk_q <= blk_q & ~(PW'(1) << lvl_q);
				lvl_q <= lvl_q + OW'(1);
			end
			bpa_pkg::OP_RESULT: begin
				res_status <= cmd.rstat;
				if (cmd.rstat == bpa_pkg::RS_OK) begin
					res_address <= base_q + AW'({pg_q, {bpa_pkg::PAGE_LOG{1'b0}}});
					res_order <= ord_q;
				end else begin
					res_address <= '0;
					res_order <= '0;
				end
			end
			default: ;
		endcase
	end

	// status to the controller
	always_comb begin
		sts.is_free_req = kind_q;
		sts.too_large   = tl_q;
		sts.no_free     = nf_q;
		sts.bad_addr    = bad_q;
		sts.rd          = bpa_pkg::bstat_t'(rdata);
		sts.aligned     = (pg_q & amask) == '0;
		sts.ord_top     = ord_q == OW'(bpa_pkg::TOP_ORDER);
		sts.lvl_top     = lvl_q == OW'(bpa_pkg::TOP_ORDER);
		sts.lvl_ne_ord  = lvl_q != ord_q;
		sts.ord_zero    = ord_q == '0;
		sts.child_last  = (jj_q == jj_end) && (kk_q == ord_q - OW'(1));
		sts.scan_last   = n_q == SW'(bpa_pkg::TABLE_SIZE - 1);
		sts.clear_last  = n_q == SW'(bpa_pkg::TABLE_SIZE - 1);
	end

endmodule

### design/bpa_ctrl.sv
// Controller state machine: sequences table reads, writes and scans per request.
// Depends on bpa_pkg; drives bpa_datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module bpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output bpa_pkg::cmd_t cmd,
	input  bpa_pkg::sts_t sts
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DISPATCH, S_SPLIT_CHK, S_SPLIT_A, S_SPLIT_B, S_MARK,
		S_CHILD, S_RD_P0, S_CHK_P0, S_O_CHK, S_RD_O1, S_O_EVAL, S_O_INC,
		S_MERGE_INIT, S_M_CHK, S_RD_BUD, S_M_EVAL, S_MERGE_A, S_MERGE_B,
		S_SET_FREE, S_SCAN_START, S_SCAN, S_WAIT, S_LOAD
	} state_t;

	state_t state_q, nxt;
	bpa_pkg::op_t op_q;
	bpa_pkg::rstat_t rstat_q, nxt_rstat;
	logic rdy_q, ov_q;

	// operation issued while in a state
	function automatic bpa_pkg::op_t op_of(input state_t s);
		case (s)
			S_CLEAR:      op_of = bpa_pkg::OP_CLEAR;
			S_SPLIT_A:    op_of = bpa_pkg::OP_SPLIT_A;
			S_SPLIT_B:    op_of = bpa_pkg::OP_SPLIT_B;
			S_MARK:       op_of = bpa_pkg::OP_MARK;
			S_CHILD:      op_of = bpa_pkg::OP_CHILD;
			S_RD_P0:      op_of = bpa_pkg::OP_RD_P0;
			S_RD_O1:      op_of = bpa_pkg::OP_RD_O1;
			S_O_INC:      op_of = bpa_pkg::OP_O_INC;
			S_MERGE_INIT: op_of = bpa_pkg::OP_MERGE_INIT;
			S_RD_BUD:     op_of = bpa_pkg::OP_RD_BUD;
			S_MERGE_A:    op_of = bpa_pkg::OP_MERGE_A;
			S_MERGE_B:    op_of = bpa_pkg::OP_MERGE_B;
			S_SET_FREE:   op_of = bpa_pkg::OP_SET_FREE;
			S_SCAN_START: op_of = bpa_pkg::OP_SCAN_START;
			S_SCAN:       op_of = bpa_pkg::OP_SCAN;
			S_LOAD:       op_of = bpa_pkg::OP_RESULT;
			default:      op_of = bpa_pkg::OP_NONE;
		endcase
	endfunction

	// next state
	always_comb begin
		nxt = state_q;
		nxt_rstat = rstat_q;
		case (state_q)
			S_CLEAR: if (sts.clear_last) nxt = S_IDLE;
			S_IDLE: if (in_valid && rdy_q) nxt = S_DISPATCH;
			S_DISPATCH: begin
				if (sts.is_free_req) begin
					if (sts.bad_addr) begin
						nxt = S_WAIT;
						nxt_rstat = bpa_pkg::RS_BAD_FREE;
					end else begin
						nxt = S_RD_P0;
					end
				end else if (sts.too_large) begin
					nxt = S_WAIT;
					nxt_rstat = bpa_pkg::RS_TOO_LARGE;
				end else if (sts.no_free) begin
					nxt = S_WAIT;
					nxt_rstat = bpa_pkg::RS_NO_FREE;
				end else begin
					nxt = S_SPLIT_CHK;
				end
			end
			S_SPLIT_CHK: nxt = sts.lvl_ne_ord ? S_SPLIT_A : S_MARK;
			S_SPLIT_A: nxt = S_SPLIT_B;
			S_SPLIT_B: nxt = S_SPLIT_CHK;
			S_MARK: nxt = sts.ord_zero ? S_SCAN_START : S_CHILD;
			S_CHILD: begin
				if (sts.child_last) nxt = sts.is_free_req ? S_MERGE_INIT : S_SCAN_START;
			end
			S_RD_P0: nxt = S_CHK_P0;
			S_CHK_P0: begin
				if (sts.rd != bpa_pkg::BS_ALLOC) begin
					nxt = S_WAIT;
					nxt_rstat = bpa_pkg::RS_BAD_FREE;
				end else begin
					nxt = S_O_CHK;
				end
			end
			S_O_CHK: nxt = sts.ord_top ? S_CHILD : S_RD_O1;
			S_RD_O1: nxt = S_O_EVAL;
			S_O_EVAL: begin
				if (sts.rd == bpa_pkg::BS_ALLOC) begin
					if (sts.aligned) begin
						nxt = S_O_INC;
					end else begin
						nxt = S_WAIT;
						nxt_rstat = bpa_pkg::RS_BAD_FREE;
					end
				end else begin
					nxt = sts.ord_zero ? S_MERGE_INIT : S_CHILD;
				end
			end
			S_O_INC: nxt = S_O_CHK;
			S_MERGE_INIT: nxt = S_M_CHK;
			S_M_CHK: nxt = sts.lvl_top ? S_SET_FREE : S_RD_BUD;
			S_RD_BUD: nxt = S_M_EVAL;
			S_M_EVAL: nxt = (sts.rd == bpa_pkg::BS_FREE) ? S_MERGE_A : S_SET_FREE;
			S_MERGE_A: nxt = S_MERGE_B;
			S_MERGE_B: nxt = S_M_CHK;
			S_SET_FREE: nxt = S_SCAN_START;
			S_SCAN_START: nxt = S_SCAN;
			S_SCAN: begin
				if (sts.scan_last) begin
					nxt = S_WAIT;
					nxt_rstat = bpa_pkg::RS_OK;
				end
			end
			S_WAIT: if (!ov_q || out_ready) nxt = S_LOAD;
			S_LOAD: nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			op_q <= bpa_pkg::OP_CLEAR;
			rstat_q <= bpa_pkg::RS_OK;
			rdy_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= nxt;
			op_q <= op_of(nxt);
			rstat_q <= nxt_rstat;
			rdy_q <= (nxt == S_IDLE);
			if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			if (state_q == S_LOAD) begin
				ov_q <= 1'b1;
			end
		end
	end

	assign in_ready  = rdy_q;
	assign out_valid = ov_q;
	assign cmd = '{op: op_q, rstat: rstat_q, load: in_valid && rdy_q};

endmodule

### design/buddy_page_allocator_top.sv
// Top level of the buddy page allocator: stream ports, config port, controller and datapath.
// Depends on bpa_pkg, bpa_ram, bpa_datapath and bpa_ctrl.
`timescale 1ns / 1ps

// Buddy allocator over 512 pages of 4 KiB starting at region_base. Each request
// word gives one result word. After reset a clearing pass runs through the
// status table RAM before the first request is taken; cfg writes are taken at
// any time. Every request that changes state ends with a rescan of all 1023
// table entries, one RAM read a cycle, to rebuild the per-order free-block
// heads. An allocate first cuts its block from a free block of higher order,
// one split level at a time, and writes its sub-blocks; a free climbs the
// order levels to find the block size, writes its sub-blocks and merges level
// by level. A request rejected at decode, or a free of a page that is not
// allocated, skips the rescan. A result word still waiting on the output holds
// the next result back.
module buddy_page_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	// request: tdata = request_bytes[23:0], free_address[71:24]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,
	// tuser = kind[0]
	input  logic [0:0]  s_axis_tuser,
	// result: tdata = block_address[47:0], block_order[51:48], zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,
	// tuser = status[1:0]
	output logic [1:0]  m_axis_tuser,
	// config: region_base
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [47:0] cfg_data
);

	bpa_pkg::cmd_t cmd;
	bpa_pkg::sts_t sts;
	logic [1:0] res_status;
	logic [bpa_pkg::ADDR_W-1:0] res_address;
	logic [bpa_pkg::ORD_W-1:0] res_order;

	assign cfg_ready = 1'b1;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	bpa_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_valid),
		.cfg_base    (cfg_data),
		.req_kind    (s_axis_tuser[0]),
		.req_bytes   (s_axis_tdata[23:0]),
		.req_addr    (s_axis_tdata[71:24]),
		.res_status  (res_status),
		.res_address (res_address),
		.res_order   (res_order)
	);

	// result word packing
	assign m_axis_tdata = {4'b0000, res_order, res_address};
	assign m_axis_tuser = res_status;

endmodule

### tb/buddy_page_allocator_top_tb.sv
// Self-checking testbench of the buddy page allocator: directed table, then random phases.
// Depends on bpa_pkg and buddy_page_allocator_top; holds its own buddy table model.
`timescale 1ns / 1ps

module buddy_page_allocator_top_tb;
	import bpa_pkg::*;

	localparam int NPAGES   = 1 << TOP_ORDER;
	localparam int NSLOTS   = (1 << NUM_ORDERS) - 1;
	localparam int MAX_REQ  = PAGE_BYTES << TOP_ORDER;
	localparam int SETTLE   = 20;
	localparam int WD_LIMIT = 60000;

	typedef struct {
		rstat_t      st;
		logic [47:0] addr;
		logic [3:0]  ord;
	} outcome_t;

	typedef struct {
		logic        kind;
		logic [23:0] bytes;
		logic [47:0] faddr;
		logic        typed;
		rstat_t      st;
		logic [47:0] addr;
		logic [3:0]  ord;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [47:0] cfg_data;

	// model state
	bstat_t      blk_tbl [NSLOTS];
	bit          head_ok [NUM_ORDERS];
	int          head_pg [NUM_ORDERS];
	logic [47:0] base_m;

	outcome_t    pending_q [$];
	int          live_pages [$];
	int          err_cnt;
	int          idle_cycles;
	bit          drain_each;

	buddy_page_allocator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int tbl_idx(int k, int pg);
		return (1 << NUM_ORDERS) - (1 << (NUM_ORDERS - k)) + ((pg & (NPAGES - 1)) >> k);
	endfunction

	function automatic void rebuild_heads();
		for (int k = 0; k < NUM_ORDERS; k++) begin
			head_ok[k] = 1'b0;
			head_pg[k] = 0;
			for (int p = 0; p < NPAGES; p += (1 << k)) begin
				if (blk_tbl[tbl_idx(k, p)] == BS_FREE) begin
					head_ok[k] = 1'b1;
					head_pg[k] = p;
					break;
				end
			end
		end
	endfunction

	function automatic void mark_subblocks(int o, int s, bstat_t v);
		for (int k = 0; k < o; k++)
			for (int p = s; p < s + (1 << o); p += (1 << k))
				blk_tbl[tbl_idx(k, p)] = v;
	endfunction

	function automatic logic [47:0] page_to_addr(int p);
		return base_m + 48'(p) * 48'(PAGE_BYTES);
	endfunction

	function automatic void model_reset();
		foreach (blk_tbl[n]) blk_tbl[n] = BS_ABSORBED;
		blk_tbl[tbl_idx(TOP_ORDER, 0)] = BS_FREE;
		base_m = '0;
		rebuild_heads();
	endfunction

	// allocate: smallest fitting order, split down from the lowest free block
	function automatic outcome_t model_alloc(logic [23:0] req);
		outcome_t r;
		int t, i, s;
		r = '{RS_OK, '0, '0};
		t = 0;
		i = 0;
		if (req > MAX_REQ) begin
			r.st = RS_TOO_LARGE;
			return r;
		end
		while (t < TOP_ORDER && (PAGE_BYTES << t) < req) t++;
		for (i = t; i < NUM_ORDERS; i++)
			if (head_ok[i]) break;
		if (i == NUM_ORDERS) begin
			r.st = RS_NO_FREE;
			return r;
		end
		s = head_pg[i];
		for (int k = i; k > t; k--) begin
			blk_tbl[tbl_idx(k, s)] = BS_SPLIT;
			blk_tbl[tbl_idx(k - 1, s + (1 << (k - 1)))] = BS_FREE;
		end
		blk_tbl[tbl_idx(t, s)] = BS_ALLOC;
		mark_subblocks(t, s, BS_ALLOC);
		rebuild_heads();
		live_pages.push_back(s);
		r.addr = page_to_addr(s);
		r.ord = 4'(t);
		return r;
	endfunction

	// free: locate the block that starts here, clear it and merge upward
	function automatic outcome_t model_free(logic [47:0] a);
		outcome_t r;
		logic [47:0] diff;
		int p, o, b, bud;
		r = '{RS_BAD_FREE, '0, '0};
		o = 0;
		if (a < base_m) return r;
		diff = a - base_m;
		if (diff[11:0] != 0) return r;
		if ((diff >> 12) >= NPAGES) return r;
		p = int'(diff >> 12);
		if (blk_tbl[tbl_idx(0, p)] != BS_ALLOC) return r;
		while (o < TOP_ORDER && (p & ((1 << (o + 1)) - 1)) == 0
				&& blk_tbl[tbl_idx(o + 1, p)] == BS_ALLOC)
			o++;
		if (o < TOP_ORDER && blk_tbl[tbl_idx(o + 1, p)] == BS_ALLOC) return r;
		mark_subblocks(o, p, BS_ABSORBED);
		b = p;
		for (int i = o; ; i++) begin
			if (i == TOP_ORDER) begin
				blk_tbl[tbl_idx(i, b)] = BS_FREE;
				break;
			end
			bud = b ^ (1 << i);
			if (blk_tbl[tbl_idx(i, bud)] == BS_FREE) begin
				blk_tbl[tbl_idx(i, b)] = BS_ABSORBED;
				blk_tbl[tbl_idx(i, bud)] = BS_ABSORBED;
				b &= ~(1 << i);
			end else begin
				blk_tbl[tbl_idx(i, b)] = BS_FREE;
				break;
			end
		end
		rebuild_heads();
		foreach (live_pages[n]) begin
			if (live_pages[n] == p) begin
				live_pages.delete(n);
				break;
			end
		end
		r.st = RS_OK;
		r.addr = page_to_addr(p);
		r.ord = 4'(o);
		return r;
	endfunction

	// send one request word; the outcome is predicted at acceptance
	task automatic send_request(input row_t rw);
		int gap;
		outcome_t r;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
		if (drain_each) begin
			s_axis_tvalid <= 1'b0;
			while (pending_q.size() != 0) @(posedge clk);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {rw.faddr, rw.bytes};
		s_axis_tuser  <= rw.kind;
		do @(posedge clk); while (!s_axis_tready);
		r = rw.kind ? model_free(rw.faddr) : model_alloc(rw.bytes);
		if (rw.typed) r = '{rw.st, rw.addr, rw.ord};
		pending_q.push_back(r);
	endtask

	// register write once the block has gone quiet
	task automatic write_base(input logic [47:0] v);
		s_axis_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		base_m = v;
	endtask

	function automatic row_t pick_random(int alloc_pct);
		row_t rw;
		int r, o, sel;
		rw = '{1'b0, '0, '0, 1'b0, RS_OK, '0, '0};
		r = $urandom_range(0, 99);
		if (r < alloc_pct || (r < 88 && live_pages.size() == 0)) begin
			sel = $urandom_range(0, 31);
			o = sel < 16 ? 0 : sel < 24 ? 1 : sel < 28 ? 2 : sel < 30 ? $urandom_range(3, 6)
				: $urandom_range(7, TOP_ORDER);
			if ($urandom_range(0, 24) == 0)
				rw.bytes = 24'($urandom);
			else if (o == 0)
				rw.bytes = 24'($urandom_range(0, PAGE_BYTES));
			else
				rw.bytes = 24'($urandom_range((PAGE_BYTES << (o - 1)) + 1, PAGE_BYTES << o));
		end else if (r < 88) begin
			rw.kind = 1'b1;
			rw.faddr = page_to_addr(live_pages[$urandom_range(0, live_pages.size() - 1)]);
		end else begin
			rw.kind = 1'b1;
			case ($urandom_range(0, 3))
				0: rw.faddr = {16'($urandom), 32'($urandom)};
				1: rw.faddr = page_to_addr($urandom_range(0, NPAGES - 1));
				2: rw.faddr = page_to_addr($urandom_range(0, NPAGES - 1))
					+ 48'($urandom_range(1, PAGE_BYTES - 1));
				default: rw.faddr = base_m - 48'(PAGE_BYTES);
			endcase
		end
		return rw;
	endfunction

	// result checker
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result word status=%0d", m_axis_tuser);
				err_cnt++;
			end else begin
				e = pending_q.pop_front();
				if (m_axis_tuser != e.st) begin
					$error("status: expected %0d, got %0d", e.st, m_axis_tuser);
					err_cnt++;
				end
				if (m_axis_tdata[47:0] != e.addr) begin
					$error("block_address: expected %h, got %h", e.addr, m_axis_tdata[47:0]);
					err_cnt++;
				end
				if (m_axis_tdata[51:48] != e.ord) begin
					$error("block_order: expected %0d, got %0d", e.ord, m_axis_tdata[51:48]);
					err_cnt++;
				end
			end
		end
	end

	// result-side stalls
	initial begin
		int n;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0;
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	// watchdog on cycles without any word moving
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("buddy_page_allocator_top_tb: errors");
			$finish;
		end
	end

	// stimulus
	initial begin
		row_t        dir_rows [$];
		logic [47:0] phase_base [5];
		int          alloc_mix [5];
		err_cnt = 0;
		idle_cycles = 0;
		drain_each = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		model_reset();
		dir_rows = '{
			'{1'b1, 24'd0, 48'h0, 1'b1, RS_BAD_FREE, 48'h0, 4'd0},
			'{1'b0, 24'd0, 48'h0, 1'b1, RS_OK, 48'h0, 4'd0},
			'{1'b0, 24'hFFFFFF, 48'h0, 1'b1, RS_TOO_LARGE, 48'h0, 4'd0},
			'{1'b0, 24'(MAX_REQ), 48'h0, 1'b1, RS_NO_FREE, 48'h0, 4'd0},
			'{1'b1, 24'd0, 48'h1001, 1'b1, RS_BAD_FREE, 48'h0, 4'd0},
			'{1'b1, 24'd0, 48'h200000, 1'b1, RS_BAD_FREE, 48'h0, 4'd0},
			'{1'b1, 24'd0, 48'h0, 1'b1, RS_OK, 48'h0, 4'd0},
			'{1'b0, 24'(MAX_REQ), 48'h0, 1'b1, RS_OK, 48'h0, 4'd9},
			'{1'b1, 24'd0, 48'h1000, 1'b1, RS_BAD_FREE, 48'h0, 4'd0},
			'{1'b1, 24'd0, 48'h0, 1'b1, RS_OK, 48'h0, 4'd9},
			'{1'b0, 24'd4097, 48'h0, 1'b0, RS_OK, 48'h0, 4'd0},
			'{1'b0, 24'd1, 48'h0, 1'b0, RS_OK, 48'h0, 4'd0},
			'{1'b0, 24'd8192, 48'h0, 1'b0, RS_OK, 48'h0, 4'd0},
			'{1'b1, 24'd0, 48'hFFFFFFFFFFFF, 1'b1, RS_BAD_FREE, 48'h0, 4'd0},
			'{1'b1, 24'd0, 48'h2000, 1'b0, RS_OK, 48'h0, 4'd0},
			'{1'b1, 24'd0, 48'h4000, 1'b0, RS_OK, 48'h0, 4'd0},
			'{1'b1, 24'd0, 48'h0, 1'b0, RS_OK, 48'h0, 4'd0}
		};
		phase_base = '{48'hFFFFFFFFFFFF, {16'($urandom), 20'($urandom), 12'h0},
			48'h0, 48'hFFFFFFE00000, {16'($urandom), 32'($urandom)}};
		alloc_mix = '{50, 45, 80, 35, 50};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[n]) send_request(dir_rows[n]);
		// random phases under several base addresses
		for (int ph = 0; ph < 5; ph++) begin
			write_base(phase_base[ph]);
			drain_each = (ph == 1);
			for (int n = 0; n < 218; n++) send_request(pick_random(alloc_mix[ph]));
			drain_each = 1'b0;
		end
		s_axis_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (err_cnt == 0)
			$display("buddy_page_allocator_top_tb: clean");
		else
			$display("buddy_page_allocator_top_tb: errors");
		$finish;
	end

endmodule

### sim.f
design/bpa_pkg.sv
design/bpa_ram.sv
design/bpa_datapath.sv
design/bpa_ctrl.sv
design/buddy_page_allocator_top.sv
tb/buddy_page_allocator_top_tb.sv
